FILE: hw/rtl/etok_pkg.sv
// ----------------------------------------------------------------------------
// etok_pkg
// Shared constants, token types and helper functions of the expression
// tokenizer: token kinds and codes, lexer modes, function-name matcher.
// ----------------------------------------------------------------------------
package etok_pkg;

  // Widths fixed by the token format
  localparam int MANT_W            = 60;
  localparam int FRAC_W            = 5;
  localparam int MANTISSA_BITS_DEF = 60;

  // Token queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Token kinds
  localparam logic [2:0] K_NUM   = 3'd0;
  localparam logic [2:0] K_VAR   = 3'd1;
  localparam logic [2:0] K_OP    = 3'd2;
  localparam logic [2:0] K_FUN   = 3'd3;
  localparam logic [2:0] K_OPEN  = 3'd4;
  localparam logic [2:0] K_CLOSE = 3'd5;
  localparam logic [2:0] K_ERR   = 3'd6;
  localparam logic [2:0] K_END   = 3'd7;

  // Token codes
  localparam logic [3:0] C_PLUS   = 4'd0;
  localparam logic [3:0] C_MINUS  = 4'd1;
  localparam logic [3:0] C_MUL    = 4'd2;
  localparam logic [3:0] C_DIV    = 4'd3;
  localparam logic [3:0] C_SIN    = 4'd4;
  localparam logic [3:0] C_COS    = 4'd5;
  localparam logic [3:0] C_TAN    = 4'd6;
  localparam logic [3:0] C_CTG    = 4'd7;
  localparam logic [3:0] C_LN     = 4'd8;
  localparam logic [3:0] C_SQRT   = 4'd9;
  localparam logic [3:0] C_UMINUS = 4'd10;
  localparam logic [3:0] C_NONE   = 4'd0;

  // Binding priorities
  localparam logic signed [2:0] PR_PAREN = -3'sd1;
  localparam logic signed [2:0] PR_ADD   = 3'sd0;
  localparam logic signed [2:0] PR_MUL   = 3'sd1;
  localparam logic signed [2:0] PR_FUN   = 3'sd2;
  localparam logic signed [2:0] PR_NONE  = 3'sd0;

  // Lexer modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_NUM  = 2'd1;
  localparam logic [1:0] MODE_PRE  = 2'd2;
  localparam logic [1:0] MODE_ERR  = 2'd3;

  // Function-name match progress
  localparam logic [3:0] P_NONE = 4'd0;
  localparam logic [3:0] P_S    = 4'd1;
  localparam logic [3:0] P_SI   = 4'd2;
  localparam logic [3:0] P_SQ   = 4'd3;
  localparam logic [3:0] P_SQR  = 4'd4;
  localparam logic [3:0] P_C    = 4'd5;
  localparam logic [3:0] P_CO   = 4'd6;
  localparam logic [3:0] P_CT   = 4'd7;
  localparam logic [3:0] P_T    = 4'd8;
  localparam logic [3:0] P_TA   = 4'd9;
  localparam logic [3:0] P_L    = 4'd10;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_0     = "0";
  localparam logic [7:0] CH_9     = "9";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_COMMA = ",";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_STAR  = "*";
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_X     = "x";
  localparam logic [7:0] CH_LPAR  = "(";
  localparam logic [7:0] CH_RPAR  = ")";
  localparam logic [7:0] CH_A     = "a";
  localparam logic [7:0] CH_C     = "c";
  localparam logic [7:0] CH_G     = "g";
  localparam logic [7:0] CH_I     = "i";
  localparam logic [7:0] CH_L     = "l";
  localparam logic [7:0] CH_N     = "n";
  localparam logic [7:0] CH_O     = "o";
  localparam logic [7:0] CH_Q     = "q";
  localparam logic [7:0] CH_R     = "r";
  localparam logic [7:0] CH_S     = "s";
  localparam logic [7:0] CH_T     = "t";

  // One token as it travels from front to back
  typedef struct packed {
    logic [2:0]        kind;
    logic [3:0]        code;
    logic [MANT_W-1:0] mant;
    logic [FRAC_W-1:0] frac;
    logic              last;
  } tok_t;

  // Up to two tokens produced by one character
  typedef struct packed {
    logic v0;
    logic v1;
    tok_t t0;
    tok_t t1;
  } push_t;

  function automatic tok_t mk_tok(logic [2:0] kind, logic [3:0] code,
                                  logic [MANT_W-1:0] mant, logic [FRAC_W-1:0] frac);
    tok_t t;
    t.kind = kind;
    t.code = code;
    t.mant = mant;
    t.frac = frac;
    t.last = 1'b0;
    return t;
  endfunction

  // Advance the function-name matcher. Returns {1'b1, code} on a complete
  // name, {1'b0, progress} on a partial match, zero on mismatch.
  function automatic logic [4:0] pfx_next(logic [3:0] p, logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    case (p)
      P_NONE: begin
        if (c == CH_S) r = {1'b0, P_S};
        else if (c == CH_C) r = {1'b0, P_C};
        else if (c == CH_T) r = {1'b0, P_T};
        else if (c == CH_L) r = {1'b0, P_L};
      end
      P_S: begin
        if (c == CH_I) r = {1'b0, P_SI};
        else if (c == CH_Q) r = {1'b0, P_SQ};
      end
      P_SI:  if (c == CH_N) r = {1'b1, C_SIN};
      P_SQ:  if (c == CH_R) r = {1'b0, P_SQR};
      P_SQR: if (c == CH_T) r = {1'b1, C_SQRT};
      P_C: begin
        if (c == CH_O) r = {1'b0, P_CO};
        else if (c == CH_T) r = {1'b0, P_CT};
      end
      P_CO:  if (c == CH_S) r = {1'b1, C_COS};
      P_CT:  if (c == CH_G) r = {1'b1, C_CTG};
      P_T:   if (c == CH_A) r = {1'b0, P_TA};
      P_TA:  if (c == CH_N) r = {1'b1, C_TAN};
      P_L:   if (c == CH_N) r = {1'b1, C_LN};
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // Binding priority of a token
  function automatic logic signed [2:0] tok_prio(logic [2:0] kind, logic [3:0] code);
    logic signed [2:0] r;
    r = PR_NONE;
    case (kind)
      K_OPEN, K_CLOSE: r = PR_PAREN;
      K_OP:            r = (code == C_MUL || code == C_DIV) ? PR_MUL : PR_ADD;
      K_FUN:           r = PR_FUN;
      default:         r = PR_NONE;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/etok_if.sv
// ----------------------------------------------------------------------------
// etok_if
// Valid/ready channels of the expression tokenizer: the character stream in
// and the token stream out.
// ----------------------------------------------------------------------------
interface etok_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

interface etok_tok_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          token_kind;
  logic [3:0]                          token_code;
  logic signed [2:0]                   priority_res;
  logic [etok_pkg::MANT_W-1:0]         mantissa;
  logic [etok_pkg::FRAC_W-1:0]         fraction_digits;
  logic                                last_of_run;

  modport source (output valid, output token_kind, output token_code,
                  output priority_res, output mantissa, output fraction_digits,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_code,
                  input priority_res, input mantissa, input fraction_digits,
                  input last_of_run, output ready);
endinterface

FILE: hw/rtl/expression_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// expression_tokenizer_unit
// Streaming arithmetic expression tokenizer: one ASCII character in per
// transaction, numbers, operators, parentheses and function tokens out.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                          per transaction
//  in_ch     in   character[7:0]                                   one character
//  out_tok   out  token_kind, token_code, priority_res, mantissa,  one token
//                 fraction_digits, last_of_run
//
//  A character is accepted in the cycle it is offered while the token queue
//  has room for two tokens; one character per cycle is sustained while the
//  queue keeps that room. Tokens reach out_tok through the queue and then
//  the output register. The back end drains one token per cycle while
//  out_tok.ready is high, so a character that yields two tokens (number
//  flush plus operator, error plus end) needs more output than input bandwidth.
//  Reset (rst_n low, synchronous) empties the queue and the output register
//  and returns the lexer to idle. Output stalls back up into the queue and
//  then hold in_ch.ready low.
// ----------------------------------------------------------------------------
module expression_tokenizer_unit #(
  parameter int MANTISSA_BITS = etok_pkg::MANTISSA_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  etok_char_if.sink   in_ch,
  etok_tok_if.source  out_tok
);

  logic            in_fire;
  etok_pkg::push_t push;
  logic            space2;
  logic            pop;
  logic            nonempty;
  etok_pkg::tok_t  head;

  assign in_ch.ready = space2;
  assign in_fire     = in_ch.valid && in_ch.ready;

  etok_front #(
    .MANTISSA_BITS (MANTISSA_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_char (in_ch.character),
    .push    (push)
  );

  etok_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space2   (space2),
    .pop      (pop),
    .head     (head),
    .nonempty (nonempty)
  );

  etok_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .nonempty (nonempty),
    .pop      (pop),
    .out_tok  (out_tok)
  );

endmodule

FILE: hw/rtl/etok_front.sv
// ----------------------------------------------------------------------------
// etok_front
// Lexer front end: classifies each accepted character, keeps the number and
// function-name state, and produces up to two tokens per character.
// ----------------------------------------------------------------------------
module etok_front #(
  parameter int MANTISSA_BITS = etok_pkg::MANTISSA_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic [7:0]           in_char,
  output etok_pkg::push_t      push
);

  localparam int MW     = etok_pkg::MANT_W;
  localparam int FW     = etok_pkg::FRAC_W;
  localparam int ACC_W  = (MANTISSA_BITS > MW) ? MW : MANTISSA_BITS;
  localparam int PROD_W = ACC_W + 4;

  logic [1:0]       mode_r,  mode_nxt;
  logic [ACC_W-1:0] acc_r,   acc_nxt;
  logic             point_r, point_nxt;
  logic [FW-1:0]    frac_r,  frac_nxt;
  logic [3:0]       pfx_r,   pfx_nxt;
  logic [2:0]       prev_r,  prev_nxt;

  logic              is_digit;
  logic [3:0]        dval;
  logic [PROD_W-1:0] prod;
  logic              ovf;
  logic [4:0]        pfx_p;
  logic [4:0]        idle_p;
  logic              do_idle;
  logic [2:0]        idle_prev;
  logic              it_v;
  etok_pkg::tok_t    it;

  // Digit value and multiply-by-ten accumulate with overflow check
  always_comb begin
    is_digit = (in_char inside {[etok_pkg::CH_0:etok_pkg::CH_9]});
    dval     = in_char[3:0];
    prod     = (PROD_W'(acc_r) << 3) + (PROD_W'(acc_r) << 1) + PROD_W'(dval);
    ovf      = |prod[PROD_W-1:ACC_W];
    pfx_p    = etok_pkg::pfx_next(pfx_r, in_char);
    idle_p   = etok_pkg::pfx_next(etok_pkg::P_NONE, in_char);
  end

  // Decide tokens and next state for the current character
  always_comb begin
    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    point_nxt = point_r;
    frac_nxt  = frac_r;
    pfx_nxt   = pfx_r;
    prev_nxt  = prev_r;
    push      = '0;
    do_idle   = 1'b0;
    idle_prev = prev_r;
    it_v      = 1'b0;
    it        = '0;

    case (mode_r)
      etok_pkg::MODE_ERR: begin
        if (in_char == etok_pkg::CH_NUL) begin
          push.v0   = 1'b1;
          push.t0   = etok_pkg::mk_tok(etok_pkg::K_END, etok_pkg::C_NONE, '0, '0);
          mode_nxt  = etok_pkg::MODE_IDLE;
          acc_nxt   = '0;
          point_nxt = 1'b0;
          frac_nxt  = '0;
          pfx_nxt   = etok_pkg::P_NONE;
          prev_nxt  = etok_pkg::K_END;
        end
      end
      etok_pkg::MODE_PRE: begin
        if (pfx_p[4]) begin
          push.v0  = 1'b1;
          push.t0  = etok_pkg::mk_tok(etok_pkg::K_FUN, pfx_p[3:0], '0, '0);
          mode_nxt = etok_pkg::MODE_IDLE;
          pfx_nxt  = etok_pkg::P_NONE;
          prev_nxt = etok_pkg::K_FUN;
        end else if (pfx_p != 5'd0) begin
          pfx_nxt = pfx_p[3:0];
        end else begin
          pfx_nxt  = etok_pkg::P_NONE;
          push.v0  = 1'b1;
          push.t0  = etok_pkg::mk_tok(etok_pkg::K_ERR, etok_pkg::C_NONE, '0, '0);
          mode_nxt = etok_pkg::MODE_ERR;
          // broken name at end of line: end token follows the error
          if (in_char == etok_pkg::CH_NUL) begin
            push.v1   = 1'b1;
            push.t1   = etok_pkg::mk_tok(etok_pkg::K_END, etok_pkg::C_NONE, '0, '0);
            mode_nxt  = etok_pkg::MODE_IDLE;
            acc_nxt   = '0;
            point_nxt = 1'b0;
            frac_nxt  = '0;
            prev_nxt  = etok_pkg::K_END;
          end
        end
      end
      etok_pkg::MODE_NUM: begin
        if (is_digit) begin
          if (ovf || (point_r && frac_r == {FW{1'b1}})) begin
            push.v0  = 1'b1;
            push.t0  = etok_pkg::mk_tok(etok_pkg::K_ERR, etok_pkg::C_NONE, '0, '0);
            mode_nxt = etok_pkg::MODE_ERR;
          end else begin
            acc_nxt = prod[ACC_W-1:0];
            if (point_r) frac_nxt = frac_r + FW'(1);
          end
        end else if (in_char == etok_pkg::CH_DOT || in_char == etok_pkg::CH_COMMA) begin
          if (point_r) begin
            push.v0  = 1'b1;
            push.t0  = etok_pkg::mk_tok(etok_pkg::K_ERR, etok_pkg::C_NONE, '0, '0);
            mode_nxt = etok_pkg::MODE_ERR;
          end else begin
            point_nxt = 1'b1;
          end
        end else begin
          // flush the number, then treat the character as from idle
          push.v0   = 1'b1;
          push.t0   = etok_pkg::mk_tok(etok_pkg::K_NUM, etok_pkg::C_NONE, MW'(acc_r), frac_r);
          mode_nxt  = etok_pkg::MODE_IDLE;
          acc_nxt   = '0;
          point_nxt = 1'b0;
          frac_nxt  = '0;
          prev_nxt  = etok_pkg::K_NUM;
          idle_prev = etok_pkg::K_NUM;
          do_idle   = 1'b1;
        end
      end
      default: do_idle = 1'b1;
    endcase

    // Idle-mode character handling
    if (do_idle) begin
      if (in_char == etok_pkg::CH_NUL) begin
        it_v      = 1'b1;
        it        = etok_pkg::mk_tok(etok_pkg::K_END, etok_pkg::C_NONE, '0, '0);
        mode_nxt  = etok_pkg::MODE_IDLE;
        acc_nxt   = '0;
        point_nxt = 1'b0;
        frac_nxt  = '0;
        pfx_nxt   = etok_pkg::P_NONE;
        prev_nxt  = etok_pkg::K_END;
      end else if (in_char == etok_pkg::CH_SPACE) begin
        it_v = 1'b0;
      end else if (is_digit) begin
        mode_nxt  = etok_pkg::MODE_NUM;
        acc_nxt   = ACC_W'(dval);
        point_nxt = 1'b0;
        frac_nxt  = '0;
      end else if (in_char == etok_pkg::CH_PLUS) begin
        it_v = 1'b1;
        it   = etok_pkg::mk_tok(etok_pkg::K_OP, etok_pkg::C_PLUS, '0, '0);
      end else if (in_char == etok_pkg::CH_MINUS) begin
        it_v = 1'b1;
        if (idle_prev inside {etok_pkg::K_NUM, etok_pkg::K_VAR, etok_pkg::K_CLOSE})
          it = etok_pkg::mk_tok(etok_pkg::K_OP, etok_pkg::C_MINUS, '0, '0);
        else
          it = etok_pkg::mk_tok(etok_pkg::K_FUN, etok_pkg::C_UMINUS, '0, '0);
      end else if (in_char == etok_pkg::CH_STAR) begin
        it_v = 1'b1;
        it   = etok_pkg::mk_tok(etok_pkg::K_OP, etok_pkg::C_MUL, '0, '0);
      end else if (in_char == etok_pkg::CH_SLASH) begin
        it_v = 1'b1;
        it   = etok_pkg::mk_tok(etok_pkg::K_OP, etok_pkg::C_DIV, '0, '0);
      end else if (in_char == etok_pkg::CH_X) begin
        it_v = 1'b1;
        it   = etok_pkg::mk_tok(etok_pkg::K_VAR, etok_pkg::C_NONE, '0, '0);
      end else if (in_char == etok_pkg::CH_LPAR) begin
        it_v = 1'b1;
        it   = etok_pkg::mk_tok(etok_pkg::K_OPEN, etok_pkg::C_NONE, '0, '0);
      end else if (in_char == etok_pkg::CH_RPAR) begin
        it_v = 1'b1;
        it   = etok_pkg::mk_tok(etok_pkg::K_CLOSE, etok_pkg::C_NONE, '0, '0);
      end else if (idle_p != 5'd0) begin
        mode_nxt = etok_pkg::MODE_PRE;
        pfx_nxt  = idle_p[3:0];
      end else begin
        it_v     = 1'b1;
        it       = etok_pkg::mk_tok(etok_pkg::K_ERR, etok_pkg::C_NONE, '0, '0);
        mode_nxt = etok_pkg::MODE_ERR;
      end

      // track the last real token for unary-minus detection
      if (it_v && it.kind <= etok_pkg::K_CLOSE) prev_nxt = it.kind;

      // place after a flushed number, if any
      if (push.v0) begin
        push.v1 = it_v;
        push.t1 = it;
      end else begin
        push.v0 = it_v;
        push.t0 = it;
      end
    end

    // mark the final token of this character
    if (push.v1) push.t1.last = 1'b1;
    else         push.t0.last = push.v0;

    // drop tokens unless a character transaction completes this cycle
    if (!in_fire) begin
      push.v0 = 1'b0;
      push.v1 = 1'b0;
    end
  end

  // State registers advance only on an accepted character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= etok_pkg::MODE_IDLE;
      acc_r   <= '0;
      point_r <= 1'b0;
      frac_r  <= '0;
      pfx_r   <= etok_pkg::P_NONE;
      prev_r  <= etok_pkg::K_END;
    end else if (in_fire) begin
      mode_r  <= mode_nxt;
      acc_r   <= acc_nxt;
      point_r <= point_nxt;
      frac_r  <= frac_nxt;
      pfx_r   <= pfx_nxt;
      prev_r  <= prev_nxt;
    end
  end

  // An end token returns the lexer to its reset state
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && ((push.v0 && push.t0.kind == etok_pkg::K_END) ||
                 (push.v1 && push.t1.kind == etok_pkg::K_END)))
    |=> (mode_r == etok_pkg::MODE_IDLE && prev_r == etok_pkg::K_END && acc_r == '0))
    else $error("end token did not clear lexer state");

  // In error mode only NUL produces anything
  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && mode_r == etok_pkg::MODE_ERR && in_char != etok_pkg::CH_NUL)
    |-> !push.v0)
    else $error("token produced while skipping after an error");

endmodule

FILE: hw/rtl/etok_queue.sv
// ----------------------------------------------------------------------------
// etok_queue
// Short token queue between front and back: takes up to two tokens per
// cycle, hands one per cycle to the back end while the back end pops.
// ----------------------------------------------------------------------------
module etok_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  etok_pkg::push_t push,
  output logic            space2,
  input  logic            pop,
  output etok_pkg::tok_t  head,
  output logic            nonempty
);

  localparam int PW = etok_pkg::QPTR_W;
  localparam int CW = etok_pkg::QCNT_W;

  etok_pkg::tok_t mem_r [etok_pkg::QDEPTH];
  logic [PW-1:0]  wr_r, wr_nxt;
  logic [PW-1:0]  rd_r, rd_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [PW-1:0]  wr_p1;

  assign space2   = (cnt_r <= CW'(etok_pkg::QDEPTH - 2));
  assign nonempty = (cnt_r != '0);
  assign head     = mem_r[rd_r];
  assign wr_p1    = wr_r + PW'(1);

  // Advance pointers and occupancy
  always_comb begin
    wr_nxt  = wr_r + PW'(push.v0) + PW'(push.v1);
    rd_nxt  = rd_r + PW'(pop);
    cnt_nxt = cnt_r + CW'(push.v0) + CW'(push.v1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store incoming tokens
  always_ff @(posedge clk) begin
    if (push.v0) mem_r[wr_r]  <= push.t0;
    if (push.v1) mem_r[wr_p1] <= push.t1;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(etok_pkg::QDEPTH))
    else $error("token queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> nonempty)
    else $error("token queue read while empty");

endmodule

FILE: hw/rtl/etok_back.sv
// ----------------------------------------------------------------------------
// etok_back
// Token back end: takes tokens from the queue, attaches the binding
// priority and holds them in the output register until taken.
// ----------------------------------------------------------------------------
module etok_back (
  input  logic           clk,
  input  logic           rst_n,
  input  etok_pkg::tok_t head,
  input  logic           nonempty,
  output logic           pop,
  etok_tok_if.source     out_tok
);

  logic                        valid_r;
  logic [2:0]                  kind_r;
  logic [3:0]                  code_r;
  logic signed [2:0]           prio_r;
  logic [etok_pkg::MANT_W-1:0] mant_r;
  logic [etok_pkg::FRAC_W-1:0] frac_r;
  logic                        last_r;

  // Load a new token when the output register is empty or being taken
  assign pop = nonempty && (!valid_r || out_tok.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || out_tok.ready) begin
      valid_r <= nonempty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r <= head.kind;
      code_r <= head.code;
      prio_r <= etok_pkg::tok_prio(head.kind, head.code);
      mant_r <= head.mant;
      frac_r <= head.frac;
      last_r <= head.last;
    end
  end

  assign out_tok.valid           = valid_r;
  assign out_tok.token_kind      = kind_r;
  assign out_tok.token_code      = code_r;
  assign out_tok.priority_res    = prio_r;
  assign out_tok.mantissa        = mant_r;
  assign out_tok.fraction_digits = frac_r;
  assign out_tok.last_of_run     = last_r;

endmodule
